// ----- hw/rtl/dsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants for the distinct subsequence counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  localparam int CountW = 30;
  localparam int SymW   = 8;
  localparam int PosW   = 6;
  localparam int LenW   = 7;

  // prime modulus for all count arithmetic
  localparam logic [CountW-1:0] Modulus = 30'd1000000007;

  typedef logic [CountW-1:0] count_t;
  typedef logic [SymW-1:0]   sym_t;
  typedef logic [PosW-1:0]   pos_t;
  typedef logic [LenW-1:0]   len_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TEXT = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dsc_ram.sv -----
// ----------------------------------------------------------------------------
// dsc_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dsc_mod_add.sv -----
// ----------------------------------------------------------------------------
// dsc_mod_add
// Modular adder: (a + b) mod prime, both operands already reduced.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_mod_add (
  input  wire dsc_pkg::count_t a,
  input  wire dsc_pkg::count_t b,
  output dsc_pkg::count_t      sum
);
  import dsc_pkg::*;

  logic [CountW:0] raw;
  logic [CountW:0] red;

  assign raw = {1'b0, a} + {1'b0, b};
  assign red = raw - {1'b0, Modulus};
  assign sum = (raw >= {1'b0, Modulus}) ? red[CountW-1:0] : raw[CountW-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/distinct_subsequence_counter.sv -----
// ----------------------------------------------------------------------------
// distinct_subsequence_counter
// Counts, mod 1000000007, the distinct occurrences of a pattern as a
// subsequence of a streamed text, one count-memory position per cycle.
// ----------------------------------------------------------------------------
// Load transaction: taken in IDLE, which it does not leave. Text transaction:
// L = active pattern length (at most PATTERN_MAX); the count RAM read port
// walks positions L down to 0, one per cycle, through a single modular adder.
// DRAIN and DONE follow; on the last byte DONE waits for a free output register.
// Reset (sync, active low) clears length, control and the count epoch; the
// pattern RAM is undefined until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_subsequence_counter #(
  parameter int PATTERN_MAX = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // configuration: pattern length
  input  wire logic            cfg_wr_en,
  input  wire dsc_pkg::len_t   cfg_wr_data,
  // input channel
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_action,
  input  wire dsc_pkg::pos_t   in_position,
  input  wire dsc_pkg::sym_t   in_symbol,
  input  wire logic            in_last,
  // result channel
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dsc_pkg::count_t      out_count
);
  import dsc_pkg::*;

  // Count RAM holds PATTERN_MAX+1 entries; pattern RAM holds PATTERN_MAX.
  localparam int CntAw = $clog2(PATTERN_MAX + 1);
  localparam int PatAw = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  len_t             pattern_length_r;
  sym_t             sym_r;
  logic             last_r;
  logic [CntAw-1:0] len_r;        // active length latched per text byte
  logic [CntAw-1:0] issue_k_r;    // position whose old count is being read
  logic             rd_valid_r;   // RAM read data valid this cycle
  logic [CntAw-1:0] rd_k_r;       // position of the data now arriving
  logic             rd_first_r;   // arriving data is entry L (nothing to write)
  count_t           hi_r;         // old count of position rd_k_r + 1
  count_t           result_r;     // new count of position L
  // High-water mark: entries above it were not written since the last
  // restart and read as zero. Entry 0 is never written and reads as one.
  logic [CntAw-1:0] hw_r;
  logic             out_valid_r;
  count_t           out_count_r;

  // --------------------------------------------------------------------------
  // Handshakes and decode
  // --------------------------------------------------------------------------
  logic             in_accept;
  logic             load_accept;
  logic             text_accept;
  logic [CntAw-1:0] act_len;
  logic             pos_ok;

  // FSM outputs
  logic             issue;
  logic             finish;
  logic             out_load;
  logic             can_load;

  assign in_accept   = in_valid && !in_stall;
  assign load_accept = in_accept && (in_action == ACT_LOAD);
  assign text_accept = in_accept && (in_action == ACT_TEXT);
  assign pos_ok      = int'(in_position) < PATTERN_MAX;

  // saturate the programmed length at the store depth
  assign act_len = (int'(pattern_length_r) > PATTERN_MAX) ? CntAw'(PATTERN_MAX)
                                                          : CntAw'(pattern_length_r);

  // output register frees when empty or taken this cycle
  assign can_load = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  sym_t   pat_rdata;
  count_t cnt_rdata;
  count_t lo_eff;
  count_t sum;
  count_t new_cnt;
  logic   match;
  logic   cnt_we;
  logic [CntAw-1:0] cnt_waddr;

  dsc_ram #(
    .Width (SymW),
    .Depth (PATTERN_MAX),
    .AddrW (PatAw)
  ) u_pat_ram (
    .clk   (clk),
    .we    (load_accept && pos_ok),
    .waddr (PatAw'(in_position)),
    .wdata (in_symbol),
    .re    (issue),
    .raddr (issue_k_r[PatAw-1:0]),
    .rdata (pat_rdata)
  );

  dsc_ram #(
    .Width (CountW),
    .Depth (PATTERN_MAX + 1),
    .AddrW (CntAw)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (new_cnt),
    .re    (issue),
    .raddr (issue_k_r),
    .rdata (cnt_rdata)
  );

  // --------------------------------------------------------------------------
  // Update datapath: entry k+1 += entry k when pattern[k] matches the byte
  // --------------------------------------------------------------------------
  assign lo_eff = (rd_k_r == '0)  ? CountW'(1) :
                  (rd_k_r > hw_r) ? '0         : cnt_rdata;

  assign match = (pat_rdata == sym_r);

  dsc_mod_add u_mod_add (
    .a   (hi_r),
    .b   (lo_eff),
    .sum (sum)
  );

  // every entry 1..L is rewritten so it joins the current epoch
  assign new_cnt   = match ? sum : hi_r;
  assign cnt_we    = rd_valid_r && !rd_first_r;
  assign cnt_waddr = rd_k_r + CntAw'(1);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (text_accept) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (issue_k_r == '0) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!last_r || can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    finish   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_WALK:  issue    = 1'b1;
      ST_DRAIN: ;
      ST_DONE: begin
        finish   = !last_r || can_load;
        out_load = last_r && can_load;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      pattern_length_r <= '0;
      rd_valid_r       <= 1'b0;
      hw_r             <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= issue;
      if (cfg_wr_en) pattern_length_r <= cfg_wr_data;
      if (finish) begin
        // last byte restarts the counts; otherwise the written range grows
        if (last_r)           hw_r <= '0;
        else if (len_r > hw_r) hw_r <= len_r;
      end
      if (out_load)                     out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (text_accept) begin
      sym_r     <= in_symbol;
      last_r    <= in_last;
      len_r     <= act_len;
      issue_k_r <= act_len;
      result_r  <= CountW'(1);   // empty pattern counts one
    end
    if (issue) begin
      rd_k_r     <= issue_k_r;
      rd_first_r <= (issue_k_r == len_r);
      if (issue_k_r != '0) issue_k_r <= issue_k_r - CntAw'(1);
    end
    if (rd_valid_r) begin
      hi_r <= lo_eff;
      if (cnt_we && (cnt_waddr == len_r)) result_r <= new_cnt;
    end
    if (out_load) out_count_r <= result_r;
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: distinct_subsequence_counter testbench
// Pattern loads and text bytes go in over the input channel and counts come
// back on the result channel. A behavioral mirror of the pattern store and the
// per-position occurrence counts predicts each count. A short directed table
// runs first, then random phases, each at its own pattern length.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsc_pkg::*;

  localparam int PATTERN_MAX  = 64;
  localparam int TOTAL_ITEMS  = 1550;
  localparam int DRAIN_CYCLES = 80;    // longer than the worst text transaction
  localparam int LONG_HOLD    = 400;   // result side hold-off, in cycles
  localparam int QUIET_LIMIT  = 3000;  // watchdog: cycles with no transaction

  typedef struct packed {
    action_t act;
    pos_t    pos;
    sym_t    sym;
    logic    last;
  } txn_t;

  // directed table: either a transaction or a length register write
  typedef enum logic {
    ROW_TXN,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    len_t      len;
    action_t   act;
    pos_t      pos;
    sym_t      sym;
    logic      last;
    logic      typed;   // count below is the expected value
    count_t    val;
  } dir_row_t;

  localparam int DIR_N = 24;

  // Length 0 at reset. The typed counts can be read straight off the rows.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty pattern: every text counts 1
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'h00, 1'b1, 1'b1, 30'd1},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'hFF, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'hA5, 1'b1, 1'b1, 30'd1},
    // last flag on a load is ignored, top position
    '{ROW_TXN, 7'd0, ACT_LOAD, 6'd63, 8'hFF, 1'b1, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_LOAD, 6'd0,  8'hFF, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_LOAD, 6'd1,  8'h00, 1'b0, 1'b0, 30'd0},
    // pattern FF 00 in text FF 00 FF 00: three occurrences
    '{ROW_CFG, 7'd2, ACT_TEXT, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'hFF, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd9,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'hFF, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd63, 8'h00, 1'b1, 1'b1, 30'd3},
    // no occurrence
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'h00, 1'b1, 1'b1, 30'd0},
    // length shrinks mid-text: the count at position 1 is kept
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'hFF, 1'b0, 1'b0, 30'd0},
    '{ROW_CFG, 7'd1, ACT_TEXT, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'h00, 1'b1, 1'b1, 30'd1},
    // pattern 00 00
    '{ROW_TXN, 7'd0, ACT_LOAD, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_CFG, 7'd2, ACT_TEXT, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    // shrink, advance position 1 only, grow back: position 2 is left alone
    '{ROW_CFG, 7'd1, ACT_TEXT, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_CFG, 7'd2, ACT_TEXT, 6'd0,  8'h00, 1'b0, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'h11, 1'b1, 1'b0, 30'd0},
    '{ROW_TXN, 7'd0, ACT_TEXT, 6'd0,  8'hFF, 1'b1, 1'b0, 30'd0}
  };

  // random phases open with the register extremes and saturation
  localparam int FORCED_N = 6;
  localparam int unsigned FORCED_LENS [FORCED_N] = '{64, 127, 65, 1, 0, 2};

  logic   clk;
  logic   rst_n;
  logic   cfg_wr_en;
  len_t   cfg_wr_data;
  logic   in_valid;
  logic   in_stall;
  logic   in_action;
  pos_t   in_position;
  sym_t   in_symbol;
  logic   in_last;
  logic   out_valid;
  logic   out_stall;
  count_t out_count;

  distinct_subsequence_counter #(
    .PATTERN_MAX(PATTERN_MAX)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_position(in_position),
    .in_symbol  (in_symbol),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_count  (out_count)
  );

  // --------------------------------------------------------------------------
  // Mirror of the block state
  // --------------------------------------------------------------------------
  sym_t   pat_mirror [PATTERN_MAX];
  count_t occ_counts [PATTERN_MAX+1];   // occ_counts[j]: matches of pattern[0..j-1]
  len_t   len_mirror;
  bit     pos_loaded [PATTERN_MAX];     // text never reads an unloaded position

  count_t pending_counts [$];           // counts owed by the block, oldest first
  int     mismatches;
  int     items_sent;
  int     quiet_cycles;

  bit     tx_steady;       // sender: no gaps this phase
  bit     rx_steady;       // receiver: no stalls this phase
  bit     long_hold_req;   // receiver: one long hold-off

  function automatic void restart_counts();
    foreach (occ_counts[i]) occ_counts[i] = '0;
    occ_counts[0] = count_t'(1);
  endfunction

  // Advance the mirror by one transaction; hand back the count it releases.
  task automatic track_subsequences(input txn_t t, output bit has_cnt, output count_t cnt);
    int unsigned      act_len;
    int               j;
    logic [CountW:0]  sum;
    has_cnt = 1'b0;
    cnt     = '0;
    if (t.act == ACT_LOAD) begin
      pat_mirror[t.pos] = t.sym;
      return;
    end
    act_len = (len_mirror > PATTERN_MAX) ? PATTERN_MAX : len_mirror;
    // high to low, so each byte extends a match by one position at most
    for (j = act_len; j >= 1; j--) begin
      if (pat_mirror[j-1] == t.sym) begin
        sum = occ_counts[j] + occ_counts[j-1];
        if (sum >= Modulus) sum = sum - Modulus;
        occ_counts[j] = sum[CountW-1:0];
      end
    end
    if (t.last) begin
      has_cnt = 1'b1;
      cnt     = occ_counts[act_len];
      restart_counts();
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Input side: drive at negedge, transaction taken at posedge
  // --------------------------------------------------------------------------
  task automatic send_txn(input txn_t t, input bit typed, input count_t typed_val);
    int     gap;
    bit     has_cnt;
    count_t cnt;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= t.act;
    in_position <= t.pos;
    in_symbol   <= t.sym;
    in_last     <= t.last;
    do @(posedge clk); while (in_stall);
    track_subsequences(t, has_cnt, cnt);
    if (t.act == ACT_LOAD) pos_loaded[t.pos] = 1'b1;
    if (has_cnt) pending_counts.push_back(typed ? typed_val : cnt);
    items_sent++;
    @(negedge clk);
  endtask

  // Block idle: nothing owed, and long enough for a count-free text byte
  // to finish its walk.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input len_t v);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    len_mirror  = v;
  endtask

  function automatic txn_t mk_txn(action_t a, int unsigned p, sym_t s, logic l);
    txn_t t;
    t.act  = a;
    t.pos  = pos_t'(p);
    t.sym  = s;
    t.last = l;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Random phase: set a length, make sure the active pattern is loaded, then
  // stream a few texts drawn from the same alphabet as the pattern.
  // --------------------------------------------------------------------------
  task automatic run_random_phase(input int unsigned len_val, input bit with_hold);
    int unsigned act_len;
    int unsigned alpha_n;
    int unsigned alpha_base;
    int unsigned n_seq;
    int unsigned seq_len;
    int unsigned p;
    int unsigned s;
    int unsigned b;
    sym_t        sym;
    write_length(len_t'(len_val));
    act_len    = (len_val > PATTERN_MAX) ? PATTERN_MAX : len_val;
    tx_steady  = ($urandom_range(0, 3) == 0);
    rx_steady  = ($urandom_range(0, 3) == 0);
    // narrow alphabets give many matches and drive counts past the modulus
    alpha_n    = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
    alpha_base = $urandom_range(0, 255);
    for (p = 0; p < act_len; p++) begin
      if (!pos_loaded[p] || $urandom_range(0, 1) == 1) begin
        sym = sym_t'(alpha_base + $urandom_range(0, alpha_n - 1));
        send_txn(mk_txn(ACT_LOAD, p, sym, 1'($urandom_range(0, 1))), 1'b0, '0);
      end
    end
    if (with_hold) long_hold_req = 1'b1;
    // during the hold-off, one-byte texts keep counts coming until the
    // output register is full and the input stalls
    n_seq = with_hold ? $urandom_range(4, 8) : $urandom_range(2, 8);
    for (s = 0; s < n_seq && items_sent < TOTAL_ITEMS; s++) begin
      if (with_hold)
        seq_len = 1;
      else if (alpha_n <= 2 && $urandom_range(0, 4) == 0)
        seq_len = $urandom_range(act_len + 1, 3 * act_len + 12);
      else
        seq_len = $urandom_range(1, 10);
      for (b = 0; b < seq_len; b++) begin
        // stray load mid-text: rewrites the pattern under the running counts
        if ($urandom_range(0, 9) == 0) begin
          sym = sym_t'(alpha_base + $urandom_range(0, alpha_n - 1));
          send_txn(mk_txn(ACT_LOAD, $urandom_range(0, PATTERN_MAX - 1), sym,
                          1'($urandom_range(0, 1))), 1'b0, '0);
        end
        sym = sym_t'(alpha_base + $urandom_range(0, alpha_n - 1));
        send_txn(mk_txn(ACT_TEXT, $urandom_range(0, PATTERN_MAX - 1), sym,
                        1'(b == seq_len - 1)), 1'b0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          r;
    int          phase_idx;
    int unsigned len_val;
    dir_row_t    row;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_action     = ACT_LOAD;
    in_position   = '0;
    in_symbol     = '0;
    in_last       = 1'b0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    long_hold_req = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    len_mirror    = '0;
    foreach (pat_mirror[i]) pat_mirror[i] = '0;
    foreach (pos_loaded[i]) pos_loaded[i] = 1'b0;
    restart_counts();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (r = 0; r < DIR_N; r++) begin
      row = DIR_ROWS[r];
      if (row.kind == ROW_CFG)
        write_length(row.len);
      else
        send_txn(mk_txn(row.act, row.pos, row.sym, row.last), row.typed, row.val);
    end

    // random phases; the third one also carries the long result hold-off
    phase_idx = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (phase_idx < FORCED_N)
        len_val = FORCED_LENS[phase_idx];
      else if ($urandom_range(0, 9) < 7)
        len_val = $urandom_range(0, 16);
      else if ($urandom_range(0, 2) != 0)
        len_val = $urandom_range(17, PATTERN_MAX);
      else
        len_val = $urandom_range(PATTERN_MAX + 1, 127);
      run_random_phase(len_val, phase_idx == 2);
      phase_idx++;
    end

    // drain, then give stray results a chance to show up
    settle_idle();
    if (mismatches == 0) begin
      $display("distinct_subsequence_counter verification clean");
    end else begin
      $display("distinct_subsequence_counter verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall per transaction, one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = rx_steady ? 0 : $urandom_range(0, 8);
      if (long_hold_req) begin
        n = n + LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result check against the oldest owed count
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $error("count: none expected, actual %0d", out_count);
        mismatches++;
      end else begin
        if (out_count !== pending_counts[0]) begin
          $error("count: expected %0d, actual %0d", pending_counts[0], out_count);
          mismatches++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  // Watchdog: too long without a transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("distinct_subsequence_counter verification failed");
        $finish;
      end
    end
  end

  initial quiet_cycles = 0;

endmodule
